>>> sv/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that a build can compile out with NO_ASSERTIONS.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/u8u16_pkg.sv
//------------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder.
//------------------------------------------------------------------------------
package u8u16_pkg;

    // Byte class boundaries.
    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] ASCII_FIRST    = 8'h01;
    localparam logic [7:0] ASCII_LAST     = 8'h7f;
    localparam logic [7:0] LEAD2_FIRST    = 8'hc0;
    localparam logic [7:0] LEAD2_LAST     = 8'hdf;
    localparam logic [7:0] LEAD3_FIRST    = 8'he0;
    localparam logic [7:0] LEAD3_LAST     = 8'hef;

    localparam logic [15:0] COUNT_MAX     = 16'hffff;
    localparam logic [15:0] BYTES_PER_UNIT = 16'd2;

    typedef enum logic [2:0] {
        CLS_NUL,
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_SKIP
    } byte_class_t;

    typedef struct packed {
        logic [1:0]  pending;
        logic [9:0]  partial;
        logic [15:0] total;
    } state_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] code_unit;
        logic        is_last;
        logic [15:0] out_bytes;
    } result_t;

endpackage

>>> sv/u8u16_if.sv
//------------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for the byte input and the code unit output.
//------------------------------------------------------------------------------
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_last;
    logic [15:0] out_bytes;

    modport source (output valid, output code_unit, output is_last, output out_bytes,
                    input ready);
    modport sink (input valid, input code_unit, input is_last, input out_bytes,
                  output ready);
endinterface

>>> sv/utf8_to_utf16_decoder.sv
//------------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streams NUL-terminated UTF-8 bytes in and BMP UTF-16 code units out.
//------------------------------------------------------------------------------
//
//  Channel       Dir   Word contents
//  -----------   ---   ------------------------------------------------
//  byte_stream   in    data_byte: one UTF-8 byte, zero ends the string
//  unit_stream   out   code_unit, is_last, out_bytes (length on is_last)
//
// One byte is taken every cycle while the output is not stalled. A byte's word
// passes from the input register to the result register, where the sink can
// take it; the result register holds the word while the sink stalls.
// A word that gives no result, such as a lead byte, simply empties the input
// register. Reset clears the sequence state, the byte count and both valid
// flags. When the output is stalled the input register holds one more byte,
// and ready drops only once both registers are full.
//
`include "assert_macros.svh"

module utf8_to_utf16_decoder (
    input logic             clk,
    input logic             rst_n,
    u8u16_byte_if.sink      byte_stream,
    u8u16_unit_if.source    unit_stream
);

    // Input register: one byte waiting for the decode stage.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Sequence state carried from byte to byte.
    u8u16_pkg::state_t  state_reg;
    u8u16_pkg::state_t  state_next;

    // Result register facing the output channel.
    logic               out_valid_reg;
    u8u16_pkg::result_t res_reg;
    u8u16_pkg::result_t res_next;

    logic advance;
    logic in_take;

    // The decode stage moves when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || unit_stream.ready);
    assign in_take = byte_stream.valid && byte_stream.ready;

    assign byte_stream.ready = !in_valid_reg || advance;

    u8u16_step u_step (
        .data_byte  (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_stream.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // A byte without a result still clears a word that the sink has just taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_next.emit;
        end
        else if (unit_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_next.emit)
        begin
            res_reg <= res_next;
        end
    end

    assign unit_stream.valid     = out_valid_reg;
    assign unit_stream.code_unit = res_reg.code_unit;
    assign unit_stream.is_last   = res_reg.is_last;
    assign unit_stream.out_bytes = res_reg.out_bytes;

    // A byte held in the input register during a stall must not change.
    `ASSERT_NEXT(a_hold_input, clk, rst_n, in_valid_reg && !advance,
                 in_valid_reg && $stable(in_byte_reg))
    // A terminator leaves the decoder idle with the count cleared.
    `ASSERT_NEXT(a_nul_clears, clk, rst_n, advance && (in_byte_reg == u8u16_pkg::BYTE_NUL),
                 (state_reg.pending == 2'd0) && (state_reg.total == 16'd0))
    // A stalled result word stays presented.
    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && !unit_stream.ready,
                 out_valid_reg && $stable(res_reg))
    // At most two follow bytes are ever outstanding.
    `ASSERT_IMPLIES(a_pending_range, clk, rst_n, in_valid_reg, state_reg.pending != 2'd3)

endmodule

>>> sv/u8u16_step.sv
//------------------------------------------------------------------------------
// u8u16_step
// Decodes one byte against the current sequence state.
//------------------------------------------------------------------------------
module u8u16_step (
    input  logic [7:0]        data_byte,
    input  u8u16_pkg::state_t state,
    output u8u16_pkg::state_t state_next,
    output u8u16_pkg::result_t result
);

    u8u16_pkg::byte_class_t cls;
    logic [16:0] total_sum;
    logic [15:0] total_sat;
    logic [15:0] merged;
    logic [1:0]  pending_dec;

    always_comb
    begin
        case (data_byte) inside
            u8u16_pkg::BYTE_NUL:                              cls = u8u16_pkg::CLS_NUL;
            [u8u16_pkg::ASCII_FIRST:u8u16_pkg::ASCII_LAST]:   cls = u8u16_pkg::CLS_ASCII;
            [u8u16_pkg::LEAD2_FIRST:u8u16_pkg::LEAD2_LAST]:   cls = u8u16_pkg::CLS_LEAD2;
            [u8u16_pkg::LEAD3_FIRST:u8u16_pkg::LEAD3_LAST]:   cls = u8u16_pkg::CLS_LEAD3;
            default:                                          cls = u8u16_pkg::CLS_SKIP;
        endcase
    end

    // The count saturates, and the terminator counts its own two bytes too.
    assign total_sum   = {1'b0, state.total} + {1'b0, u8u16_pkg::BYTES_PER_UNIT};
    assign total_sat   = total_sum[16] ? u8u16_pkg::COUNT_MAX : total_sum[15:0];
    assign merged      = {state.partial, data_byte[5:0]};
    assign pending_dec = state.pending - 2'd1;

    always_comb
    begin
        state_next = state;
        result     = '0;
        if (cls == u8u16_pkg::CLS_NUL)
        begin
            // A NUL ends the string even inside a sequence; the partial unit is lost.
            result.emit      = 1'b1;
            result.is_last   = 1'b1;
            result.out_bytes = total_sat;
            state_next       = '0;
        end
        else if (state.pending != 2'd0)
        begin
            // Any nonzero byte counts as a follow byte.
            state_next.pending = pending_dec;
            if (pending_dec != 2'd0)
            begin
                state_next.partial = merged[9:0];
            end
            else
            begin
                state_next.partial = '0;
                state_next.total   = total_sat;
                result.emit        = 1'b1;
                result.code_unit   = merged;
            end
        end
        else
        begin
            unique case (cls)
                u8u16_pkg::CLS_ASCII:
                begin
                    state_next.total = total_sat;
                    result.emit      = 1'b1;
                    result.code_unit = {8'h00, data_byte};
                end
                u8u16_pkg::CLS_LEAD2:
                begin
                    state_next.partial = {5'b0, data_byte[4:0]};
                    state_next.pending = 2'd1;
                end
                u8u16_pkg::CLS_LEAD3:
                begin
                    state_next.partial = {6'b0, data_byte[3:0]};
                    state_next.pending = 2'd2;
                end
                u8u16_pkg::CLS_SKIP:
                begin
                    state_next = state;
                end
                u8u16_pkg::CLS_NUL:
                begin
                    state_next = state;
                end
            endcase
        end
    end

endmodule
